@@ rtl/core/quaternion_pd_attitude_torque_macros.svh @@
// Assertion macros shared by the attitude torque checker.
`ifndef QUATERNION_PD_ATTITUDE_TORQUE_MACROS_SVH
`define QUATERNION_PD_ATTITUDE_TORQUE_MACROS_SVH

// Property checked at every rising clock edge, switched off while reset is high.
`define QPD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising clock edge, reset cycles included.
`define QPD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/qpd_pkg.sv @@
// Types and constants of the quaternion PD attitude torque block.
package qpd_pkg;

   localparam int unsigned Q_W       = 16;
   localparam int unsigned RATE_W    = 16;
   localparam int unsigned GAIN_W    = 32;
   localparam int unsigned ERR_W     = 34;
   localparam int unsigned TORQUE_W  = 48;
   localparam int unsigned STAGES    = 5;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned AXES      = 3;

   typedef logic signed [Q_W-1:0]      q_type;
   typedef logic signed [RATE_W-1:0]   rate_type;
   typedef logic [GAIN_W-1:0]          gain_type;
   typedef logic signed [ERR_W-1:0]    err_type;
   typedef logic signed [TORQUE_W-1:0] torque_type;

   localparam torque_type TORQUE_MAX = {1'b0, {(TORQUE_W-1){1'b1}}};
   localparam torque_type TORQUE_MIN = {1'b1, {(TORQUE_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KP_ROLL  = 3'd0,
      CSR_KP_PITCH = 3'd1,
      CSR_KP_YAW   = 3'd2,
      CSR_KD_ROLL  = 3'd3,
      CSR_KD_PITCH = 3'd4,
      CSR_KD_YAW   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [STAGES-1:0] adv;
      logic [STAGES-1:0] valid;
   } pipe_ctrl_type;

endpackage

@@ rtl/core/qpd_channels.sv @@
// Request and response channel interfaces of the attitude torque block.
interface qpd_req_if import qpd_pkg::*; ();
   logic     valid;
   logic     ready;
   q_type    cur_qw;
   q_type    cur_qx;
   q_type    cur_qy;
   q_type    cur_qz;
   q_type    tgt_qw;
   q_type    tgt_qx;
   q_type    tgt_qy;
   q_type    tgt_qz;
   rate_type rate_x;
   rate_type rate_y;
   rate_type rate_z;

   modport source (
      output valid, cur_qw, cur_qx, cur_qy, cur_qz, tgt_qw, tgt_qx, tgt_qy, tgt_qz,
             rate_x, rate_y, rate_z,
      input  ready
   );
   modport sink (
      input  valid, cur_qw, cur_qx, cur_qy, cur_qz, tgt_qw, tgt_qx, tgt_qy, tgt_qz,
             rate_x, rate_y, rate_z,
      output ready
   );
endinterface

interface qpd_rsp_if import qpd_pkg::*; ();
   logic       valid;
   logic       ready;
   torque_type torque_x;
   torque_type torque_y;
   torque_type torque_z;
   logic       saturated;

   modport source (
      output valid, torque_x, torque_y, torque_z, saturated,
      input  ready
   );
   modport sink (
      input  valid, torque_x, torque_y, torque_z, saturated,
      output ready
   );
endinterface

@@ rtl/core/qpd_pipe_ctrl.sv @@
// Valid bits and stage advance enables of the torque pipeline.
module qpd_pipe_ctrl import qpd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic          out_ready,
   output pipe_ctrl_type ctrl
);

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] adv;

   // A stage takes new data when it is empty or when its content moves on,
   // so bubbles are squeezed out and a stall holds each full stage that has no empty stage ahead of it.
   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      for (int k = 0; k < STAGES; k++) begin
         if (adv[k]) begin
            valid_in[k] = (k == 0) ? in_valid : valid_ff[(k == 0) ? 0 : k - 1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctrl.adv   = adv;
   assign ctrl.valid = valid_ff;

endmodule

@@ rtl/core/qpd_quat_err.sv @@
// Error quaternion stages: sixteen partial products, then the signed sums.
module qpd_quat_err import qpd_pkg::*; (
   input  logic          clock,
   input  pipe_ctrl_type ctrl,
   input  q_type         cur_q [4],
   input  q_type         tgt_q [4],
   input  rate_type      rate_i [AXES],
   output err_type       err [AXES],
   output rate_type      rate_o [AXES]
);

   localparam int unsigned W = 0;
   localparam int unsigned X = 1;
   localparam int unsigned Y = 2;
   localparam int unsigned Z = 3;

   logic signed [2*Q_W-1:0] prod_ff [4][4];
   logic signed [2*Q_W-1:0] prod_in [4][4];
   rate_type                rate0_ff [AXES];
   rate_type                rate1_ff [AXES];
   err_type                 err_ff [AXES];
   err_type                 err_in [AXES];
   err_type                 sum_w;
   err_type                 sum_x;
   err_type                 sum_y;
   err_type                 sum_z;

   function automatic err_type ext(input logic signed [2*Q_W-1:0] v);
      ext = {{(ERR_W-2*Q_W){v[2*Q_W-1]}}, v};
   endfunction

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            prod_in[i][j] = $signed({{Q_W{cur_q[i][Q_W-1]}}, cur_q[i]})
                          * $signed({{Q_W{tgt_q[j][Q_W-1]}}, tgt_q[j]});
         end
      end
   end

   // Hamilton product of the conjugated current attitude with the target.
   always_comb begin
      sum_w = ext(prod_ff[W][W]) + ext(prod_ff[X][X]) + ext(prod_ff[Y][Y]) + ext(prod_ff[Z][Z]);
      sum_x = ext(prod_ff[W][X]) - ext(prod_ff[X][W]) - ext(prod_ff[Y][Z]) + ext(prod_ff[Z][Y]);
      sum_y = ext(prod_ff[W][Y]) + ext(prod_ff[X][Z]) - ext(prod_ff[Y][W]) - ext(prod_ff[Z][X]);
      sum_z = ext(prod_ff[W][Z]) - ext(prod_ff[X][Y]) + ext(prod_ff[Y][X]) - ext(prod_ff[Z][W]);
      // A negative scalar part means the long way round; flip to the short one.
      if (sum_w < 0) begin
         err_in[0] = -sum_x;
         err_in[1] = -sum_y;
         err_in[2] = -sum_z;
      end else begin
         err_in[0] = sum_x;
         err_in[1] = sum_y;
         err_in[2] = sum_z;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[0]) begin
         prod_ff  <= prod_in;
         rate0_ff <= rate_i;
      end
      if (ctrl.adv[1]) begin
         err_ff   <= err_in;
         rate1_ff <= rate0_ff;
      end
   end

   assign err    = err_ff;
   assign rate_o = rate1_ff;

endmodule

@@ rtl/core/qpd_axis.sv @@
// One axis of the PD law: split gain products, rescale, subtract and clamp.
module qpd_axis import qpd_pkg::*; (
   input  logic          clock,
   input  pipe_ctrl_type ctrl,
   input  err_type       err,
   input  rate_type      rate,
   input  gain_type      kp,
   input  gain_type      kd,
   output torque_type    torque,
   output logic          sat
);

   localparam int unsigned LO_W   = 17;
   localparam int unsigned HI_W   = ERR_W - LO_W;
   localparam int unsigned PL_W   = GAIN_W + LO_W;
   localparam int unsigned PH_W   = GAIN_W + HI_W + 1;
   localparam int unsigned DP_W   = GAIN_W + RATE_W + 1;
   localparam int unsigned FULL_W = PH_W + LO_W;
   localparam int unsigned P_SH   = 27;
   localparam int unsigned D_SH   = 12;
   localparam int unsigned P_W    = FULL_W - P_SH;
   localparam int unsigned D_W    = DP_W - D_SH;
   localparam int unsigned DIFF_W = P_W + 1;

   logic [LO_W-1:0]          err_lo;
   logic signed [HI_W-1:0]   err_hi;
   logic [PL_W-1:0]          pl_ff;
   logic [PL_W-1:0]          pl_in;
   logic signed [PH_W-1:0]   ph_ff;
   logic signed [PH_W-1:0]   ph_in;
   logic signed [DP_W-1:0]   dp_ff;
   logic signed [DP_W-1:0]   dp_in;
   logic signed [FULL_W-1:0] full;
   logic signed [P_W-1:0]    p_ff;
   logic signed [P_W-1:0]    p_in;
   logic signed [D_W-1:0]    d_ff;
   logic signed [D_W-1:0]    d_in;
   logic signed [DIFF_W-1:0] diff;
   logic signed [TORQUE_W:0] wide;
   logic                     over_hi;
   logic                     over_lo;
   torque_type               torque_ff;
   torque_type               torque_in;
   logic                     sat_ff;
   logic                     sat_in;

   // The 32 x 34 gain product is taken as two partial products on the
   // low and high halves of the error and recombined one stage later.
   always_comb begin
      err_lo = err[LO_W-1:0];
      err_hi = err[ERR_W-1:LO_W];
      pl_in  = {{LO_W{1'b0}}, kp} * {{GAIN_W{1'b0}}, err_lo};
      ph_in  = $signed({{(HI_W+1){1'b0}}, kp}) * $signed({{(GAIN_W+1){err_hi[HI_W-1]}}, err_hi});
      dp_in  = $signed({{(RATE_W+1){1'b0}}, kd}) * $signed({{(GAIN_W+1){rate[RATE_W-1]}}, rate});
   end

   // Arithmetic right shifts give the floor of both scaled products.
   always_comb begin
      full = $signed({ph_ff, {LO_W{1'b0}}}) + $signed({{(FULL_W-PL_W){1'b0}}, pl_ff});
      p_in = full[FULL_W-1:P_SH];
      d_in = dp_ff[DP_W-1:D_SH];
   end

   always_comb begin
      diff    = $signed({p_ff[P_W-1], p_ff}) - $signed({{(DIFF_W-D_W){d_ff[D_W-1]}}, d_ff});
      wide    = {{(TORQUE_W+1-DIFF_W){diff[DIFF_W-1]}}, diff};
      over_hi = wide > $signed({TORQUE_MAX[TORQUE_W-1], TORQUE_MAX});
      over_lo = wide < $signed({TORQUE_MIN[TORQUE_W-1], TORQUE_MIN});
      if (over_hi) begin
         torque_in = TORQUE_MAX;
      end else if (over_lo) begin
         torque_in = TORQUE_MIN;
      end else begin
         torque_in = wide[TORQUE_W-1:0];
      end
      sat_in = over_hi || over_lo;
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[2]) begin
         pl_ff <= pl_in;
         ph_ff <= ph_in;
         dp_ff <= dp_in;
      end
      if (ctrl.adv[3]) begin
         p_ff <= p_in;
         d_ff <= d_in;
      end
      if (ctrl.adv[4]) begin
         torque_ff <= torque_in;
         sat_ff    <= sat_in;
      end
   end

   assign torque = torque_ff;
   assign sat    = sat_ff;

endmodule

@@ rtl/core/quaternion_pd_attitude_torque.sv @@
// Top level of the quaternion error PD attitude torque controller.
//
// Each request on req_if carries the current and target attitude
// quaternions (Q2.14) and the body rate (Q4.12 rad/s). The block forms the
// error quaternion, takes the short rotation, and returns on rsp_if one
// response per request with the three axis torques (Q32.16, 48 bits) and a
// flag that is set when any axis was clamped.
// Gains are written through the csr_ port, one register per write; the
// user must write them only while no request is in flight, which the
// block does not enforce. An index above five is ignored. A request
// passes five stages: products, error sums, gain partial products,
// rescale, and the subtract and clamp stage that is the output register.
// Throughput is one request per cycle while rsp_if.ready does not stall it.
// When the receiver holds rsp_if.ready low, the pipeline fills up and the
// stages stall in place; empty stages still take requests until it is full.
// Reset clears all valid bits and sets every gain to zero.
module quaternion_pd_attitude_torque import qpd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   qpd_req_if.sink              req_if,
   qpd_rsp_if.source            rsp_if,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [GAIN_W-1:0]    csr_wr_data
);

   gain_type      kp_ff [AXES];
   gain_type      kp_in [AXES];
   gain_type      kd_ff [AXES];
   gain_type      kd_in [AXES];
   pipe_ctrl_type ctrl;
   q_type         cur_q [4];
   q_type         tgt_q [4];
   rate_type      rate_i [AXES];
   rate_type      rate_d [AXES];
   err_type       err [AXES];
   torque_type    torque [AXES];
   logic [AXES-1:0] sat;

   always_comb begin
      kp_in = kp_ff;
      kd_in = kd_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_KP_ROLL:  kp_in[0] = csr_wr_data;
            CSR_KP_PITCH: kp_in[1] = csr_wr_data;
            CSR_KP_YAW:   kp_in[2] = csr_wr_data;
            CSR_KD_ROLL:  kd_in[0] = csr_wr_data;
            CSR_KD_PITCH: kd_in[1] = csr_wr_data;
            CSR_KD_YAW:   kd_in[2] = csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff <= '{default: '0};
         kd_ff <= '{default: '0};
      end else begin
         kp_ff <= kp_in;
         kd_ff <= kd_in;
      end
   end

   qpd_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .out_ready (rsp_if.ready),
      .ctrl      (ctrl)
   );

   assign req_if.ready = ctrl.adv[0];

   assign cur_q  = '{req_if.cur_qw, req_if.cur_qx, req_if.cur_qy, req_if.cur_qz};
   assign tgt_q  = '{req_if.tgt_qw, req_if.tgt_qx, req_if.tgt_qy, req_if.tgt_qz};
   assign rate_i = '{req_if.rate_x, req_if.rate_y, req_if.rate_z};

   qpd_quat_err u_quat_err (
      .clock  (clock),
      .ctrl   (ctrl),
      .cur_q  (cur_q),
      .tgt_q  (tgt_q),
      .rate_i (rate_i),
      .err    (err),
      .rate_o (rate_d)
   );

   for (genvar a = 0; a < AXES; a++) begin : g_axis
      qpd_axis u_axis (
         .clock  (clock),
         .ctrl   (ctrl),
         .err    (err[a]),
         .rate   (rate_d[a]),
         .kp     (kp_ff[a]),
         .kd     (kd_ff[a]),
         .torque (torque[a]),
         .sat    (sat[a])
      );
   end

   assign rsp_if.valid     = ctrl.valid[STAGES-1];
   assign rsp_if.torque_x  = torque[0];
   assign rsp_if.torque_y  = torque[1];
   assign rsp_if.torque_z  = torque[2];
   assign rsp_if.saturated = |sat;

endmodule

@@ rtl/core/qpd_checker.sv @@
// Port-level checks of the attitude torque block and their binding.
`include "quaternion_pd_attitude_torque_macros.svh"

module qpd_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_saturated
);

   // With these operand widths no axis can reach the torque limits.
   `QPD_ASSERT(a_no_clamp, clock, reset, rsp_valid |-> !rsp_saturated, "torque clamp fired")

   // An empty output stage lets every stage advance, so a request is taken.
   `QPD_ASSERT(a_ready_when_drained, clock, reset, !rsp_valid |-> req_ready, "request refused while output empty")

   `QPD_ASSERT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "stalled response dropped")

   `QPD_ASSERT_ALWAYS(a_reset_flush, clock, reset |=> !rsp_valid, "response valid right after reset")

endmodule

bind quaternion_pd_attitude_torque qpd_checker u_qpd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_saturated (rsp_if.saturated)
);

@@ tb/tb_qpd_torque_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the attitude torque block: tracks gain writes, predicts and checks each response.
module tb_qpd_torque_checker import qpd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   qpd_req_if                   req_if,
   qpd_rsp_if                   rsp_if,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [GAIN_W-1:0]    csr_wr_data,
   output int                   mismatch_count,
   output int                   torque_pending
);

   typedef logic signed [ERR_W+1:0] wide_err_type;
   typedef logic signed [79:0]      product_type;

   typedef struct {
      torque_type x;
      torque_type y;
      torque_type z;
      logic       saturated;
   } torque_result_type;

   gain_type          kp_gain [AXES];
   gain_type          kd_gain [AXES];
   torque_result_type expected_torques [$];
   int                mismatches = 0;

   assign mismatch_count = mismatches;

   function automatic torque_type clamp_axis(input gain_type kp, input gain_type kd,
                                             input wide_err_type err, input rate_type rate,
                                             output logic sat);
      product_type prop;
      product_type damp;
      product_type total;
      // Arithmetic shifts of the exact products give the floor toward minus infinity.
      prop  = ($signed({1'b0, kp}) * err) >>> 27;
      damp  = ($signed({1'b0, kd}) * rate) >>> 12;
      total = prop - damp;
      sat   = 1'b0;
      if (total > product_type'(TORQUE_MAX)) begin
         sat   = 1'b1;
         total = product_type'(TORQUE_MAX);
      end
      if (total < product_type'(TORQUE_MIN)) begin
         sat   = 1'b1;
         total = product_type'(TORQUE_MIN);
      end
      return total[TORQUE_W-1:0];
   endfunction

   function automatic torque_result_type predict_torque(
         input q_type cw, input q_type cx, input q_type cy, input q_type cz,
         input q_type tw, input q_type tx, input q_type ty, input q_type tz,
         input rate_type rx, input rate_type ry, input rate_type rz);
      wide_err_type      ew;
      wide_err_type      ex;
      wide_err_type      ey;
      wide_err_type      ez;
      logic              sx;
      logic              sy;
      logic              sz;
      torque_result_type res;
      ew = cw * tw + cx * tx + cy * ty + cz * tz;
      ex = cw * tx - cx * tw - cy * tz + cz * ty;
      ey = cw * ty + cx * tz - cy * tw - cz * tx;
      ez = cw * tz - cx * ty + cy * tx - cz * tw;
      // Take the short rotation; a scalar part of exactly zero leaves the error alone.
      if (ew < 0) begin
         ex = -ex;
         ey = -ey;
         ez = -ez;
      end
      res.x = clamp_axis(kp_gain[0], kd_gain[0], ex, rx, sx);
      res.y = clamp_axis(kp_gain[1], kd_gain[1], ey, ry, sy);
      res.z = clamp_axis(kp_gain[2], kd_gain[2], ez, rz, sz);
      res.saturated = sx | sy | sz;
      return res;
   endfunction

   always @(posedge clock) begin : scoreboard
      torque_result_type want;
      torque_result_type got;
      torque_result_type fresh;
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            kp_gain[a] = '0;
            kd_gain[a] = '0;
         end
         expected_torques.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_KP_ROLL:  kp_gain[0] = csr_wr_data;
               CSR_KP_PITCH: kp_gain[1] = csr_wr_data;
               CSR_KP_YAW:   kp_gain[2] = csr_wr_data;
               CSR_KD_ROLL:  kd_gain[0] = csr_wr_data;
               CSR_KD_PITCH: kd_gain[1] = csr_wr_data;
               CSR_KD_YAW:   kd_gain[2] = csr_wr_data;
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            fresh = predict_torque(
               req_if.cur_qw, req_if.cur_qx, req_if.cur_qy, req_if.cur_qz,
               req_if.tgt_qw, req_if.tgt_qx, req_if.tgt_qy, req_if.tgt_qz,
               req_if.rate_x, req_if.rate_y, req_if.rate_z);
            expected_torques.insert(expected_torques.size(), fresh);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.x         = rsp_if.torque_x;
            got.y         = rsp_if.torque_y;
            got.z         = rsp_if.torque_z;
            got.saturated = rsp_if.saturated;
            if (expected_torques.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: x=%0d y=%0d z=%0d sat=%0b",
                           got.x, got.y, got.z, got.saturated);
            end else begin
               want = expected_torques.pop_front();
               if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                   got.saturated !== want.saturated) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("torque mismatch: expected x=%0d y=%0d z=%0d sat=%0b, %s",
                              want.x, want.y, want.z, want.saturated,
                              $sformatf("got x=%0d y=%0d z=%0d sat=%0b",
                                        got.x, got.y, got.z, got.saturated));
               end
            end
         end
      end
      torque_pending <= expected_torques.size();
   end

endmodule

@@ tb/tb_quaternion_pd_attitude_torque.sv @@
`timescale 1ns / 100ps
// Testbench top for the attitude torque block: clock, reset, gain writes, requests and verdict.
module tb_quaternion_pd_attitude_torque import qpd_pkg::*;;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam int ONE  = 16384;
   localparam int QMAX = 32767;
   localparam int QMIN = -32768;

   localparam int PHASES          = 8;
   localparam int SQUEEZE_PHASE   = 4;
   localparam int SQUEEZE_CYCLES  = 300;
   localparam int PHASE_REQUESTS  = 90;
   localparam int SQUEEZE_REQUESTS = 200;
   localparam int STALL_LIMIT     = 3000;

   // Gain styles: zero, full scale, below one, any value, a mix of zero, full scale, one and any value.
   localparam int GAIN_ZERO  = 0;
   localparam int GAIN_FULL  = 1;
   localparam int GAIN_FRAC  = 2;
   localparam int GAIN_ANY   = 3;
   localparam int GAIN_MIXED = 4;

   // Word kinds: any word, modest signed value, extreme, near plus or minus one.
   localparam int WORD_ANY     = 0;
   localparam int WORD_MODEST  = 1;
   localparam int WORD_EXTREME = 2;
   localparam int WORD_UNIT    = 3;

   localparam int KP_STYLE [PHASES] = '{GAIN_ZERO, GAIN_FULL, GAIN_FULL, GAIN_ZERO,
                                        GAIN_ANY, GAIN_FRAC, GAIN_MIXED, GAIN_ANY};
   localparam int KD_STYLE [PHASES] = '{GAIN_ZERO, GAIN_FULL, GAIN_ZERO, GAIN_FULL,
                                        GAIN_ANY, GAIN_FRAC, GAIN_MIXED, GAIN_FRAC};

   typedef struct {
      q_type    cw;
      q_type    cx;
      q_type    cy;
      q_type    cz;
      q_type    tw;
      q_type    tx;
      q_type    ty;
      q_type    tz;
      rate_type rx;
      rate_type ry;
      rate_type rz;
   } attitude_update_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [GAIN_W-1:0]    csr_wr_data;
   int                   mismatch_count;
   int                   torque_pending;
   bit                   allow_gaps = 1'b1;
   bit                   squeeze_req = 1'b0;
   bit                   squeeze_done = 1'b0;

   qpd_req_if req_ch ();
   qpd_rsp_if rsp_ch ();

   quaternion_pd_attitude_torque u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   tb_qpd_torque_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_ch),
      .rsp_if         (rsp_ch),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .torque_pending (torque_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap(input bit allowed);
      int r;
      if (!allowed)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 45)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic gain_type pick_gain(input int style);
      case (style)
         GAIN_ZERO: return '0;
         GAIN_FULL: return '1;
         GAIN_FRAC: return gain_type'($urandom_range(0, 65535));
         GAIN_ANY:  return gain_type'($urandom);
         default: begin
            case ($urandom_range(0, 3))
               0:       return '0;
               1:       return '1;
               2:       return gain_type'(1);
               default: return gain_type'($urandom);
            endcase
         end
      endcase
   endfunction

   function automatic q_type rand_word(input int kind);
      int v;
      case (kind)
         WORD_ANY:    v = $urandom;
         WORD_MODEST: v = $urandom_range(0, 16000) - 8000;
         WORD_EXTREME: begin
            case ($urandom_range(0, 4))
               0:       v = QMIN;
               1:       v = QMAX;
               2:       v = 0;
               3:       v = 1;
               default: v = -1;
            endcase
         end
         default: v = (ONE - $urandom_range(0, 3000)) * ($urandom_range(0, 1) ? 1 : -1);
      endcase
      return q_type'(v);
   endfunction

   function automatic attitude_update_type random_update();
      attitude_update_type u;
      int                  pick;
      int                  kind;
      int                  part;
      pick = $urandom_range(0, 99);
      kind = (pick < 55) ? WORD_ANY : (pick < 85) ? WORD_MODEST : WORD_EXTREME;
      // Near-unit quaternions: a scalar close to plus or minus one and a modest vector part.
      part = (kind == WORD_MODEST) ? WORD_MODEST : kind;
      u.cw = rand_word((kind == WORD_MODEST) ? WORD_UNIT : kind);
      u.cx = rand_word(part);
      u.cy = rand_word(part);
      u.cz = rand_word(part);
      u.tw = rand_word((kind == WORD_MODEST) ? WORD_UNIT : kind);
      u.tx = rand_word(part);
      u.ty = rand_word(part);
      u.tz = rand_word(part);
      u.rx = rand_word(part);
      u.ry = rand_word(part);
      u.rz = rand_word(part);
      return u;
   endfunction

   function automatic attitude_update_type attitude(input int cw, input int cx, input int cy,
                                                    input int cz, input int tw, input int tx,
                                                    input int ty, input int tz, input int rx,
                                                    input int ry, input int rz);
      attitude_update_type u;
      u.cw = q_type'(cw);
      u.cx = q_type'(cx);
      u.cy = q_type'(cy);
      u.cz = q_type'(cz);
      u.tw = q_type'(tw);
      u.tx = q_type'(tx);
      u.ty = q_type'(ty);
      u.tz = q_type'(tz);
      u.rx = rate_type'(rx);
      u.ry = rate_type'(ry);
      u.rz = rate_type'(rz);
      return u;
   endfunction

   task automatic send_update(input attitude_update_type u);
      int gap;
      gap = pick_gap(allow_gaps);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.cur_qw <= u.cw;
      req_ch.cur_qx <= u.cx;
      req_ch.cur_qy <= u.cy;
      req_ch.cur_qz <= u.cz;
      req_ch.tgt_qw <= u.tw;
      req_ch.tgt_qx <= u.tx;
      req_ch.tgt_qy <= u.ty;
      req_ch.tgt_qz <= u.tz;
      req_ch.rate_x <= u.rx;
      req_ch.rate_y <= u.ry;
      req_ch.rate_z <= u.rz;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   task automatic write_gain(input logic [CSR_IDX_W-1:0] idx, input gain_type value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
   endtask

   task automatic load_gains(input int kp_style, input int kd_style);
      write_gain(CSR_KP_ROLL, pick_gain(kp_style));
      write_gain(CSR_KP_PITCH, pick_gain(kp_style));
      write_gain(CSR_KP_YAW, pick_gain(kp_style));
      write_gain(CSR_KD_ROLL, pick_gain(kd_style));
      write_gain(CSR_KD_PITCH, pick_gain(kd_style));
      write_gain(CSR_KD_YAW, pick_gain(kd_style));
      // Writes to the unused indexes must leave every gain untouched.
      write_gain(CSR_SPARE_LO, gain_type'($urandom));
      write_gain(CSR_SPARE_HI, gain_type'($urandom));
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (torque_pending != 0);
      repeat (STAGES + 3) @(posedge clock);
   endtask

   task automatic run_directed();
      send_update(attitude(ONE, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 0));
      // Scalar part exactly zero, so the error keeps its sign.
      send_update(attitude(ONE, 0, 0, 0, 0, ONE, 0, 0, 0, 0, 0));
      send_update(attitude(0, ONE, 0, 0, 0, 0, ONE, 0, -4096, 4096, 0));
      // Negative scalar part flips the vector part.
      send_update(attitude(ONE, 0, 0, 0, -11585, 11585, 0, 0, 0, 0, 0));
      send_update(attitude(-ONE, 0, 0, 0, ONE, 0, 0, 0, 4096, 0, -4096));
      // Tiny negative terms exercise rounding toward minus infinity.
      send_update(attitude(ONE, 0, 0, 0, ONE, -1, -1, -1, -1, -1, -1));
      send_update(attitude(QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX));
      send_update(attitude(QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN));
      send_update(attitude(QMAX, QMAX, QMAX, QMAX, QMIN, QMIN, QMIN, QMIN, QMIN, QMAX, QMIN));
      send_update(attitude(QMIN, QMIN, QMAX, QMIN, QMAX, QMIN, QMIN, QMIN, QMAX, QMIN, QMAX));
      send_update(attitude(QMIN, QMAX, QMIN, QMAX, QMIN, QMIN, QMAX, QMAX, 0, 0, 0));
      send_update(attitude(ONE, 0, 0, 0, ONE, 0, 0, 0, QMAX, QMIN, 1));
      // Quaternions far from unit length are used as given.
      send_update(attitude(1, 2, 3, 4, 5, -6, 7, -8, 9, -10, 11));
      send_update(attitude(0, 0, 0, 0, ONE, ONE, ONE, ONE, 0, 0, 0));
      send_update(attitude(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
   endtask

   // Response side: runs of ready with random holds, and one long hold on request.
   initial begin : response_sink
      int hold_left;
      int run_left;
      hold_left = 0;
      run_left  = 0;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (squeeze_req && !squeeze_done) begin
            rsp_ch.ready <= 1'b0;
            repeat (SQUEEZE_CYCLES) @(posedge clock);
            squeeze_done = 1'b1;
         end else begin
            if (hold_left > 0) begin
               rsp_ch.ready <= 1'b0;
               hold_left--;
            end else begin
               rsp_ch.ready <= 1'b1;
               if (run_left > 0) begin
                  run_left--;
               end else begin
                  hold_left = pick_gap(1'b1);
                  run_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                         : $urandom_range(1, 12);
               end
            end
            @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      do @(posedge clock); while (reset !== 1'b0);
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      int count;
      reset         <= 1'b1;
      csr_wr_en     <= 1'b0;
      csr_index     <= '0;
      csr_wr_data   <= '0;
      req_ch.valid  <= 1'b0;
      req_ch.cur_qw <= '0;
      req_ch.cur_qx <= '0;
      req_ch.cur_qy <= '0;
      req_ch.cur_qz <= '0;
      req_ch.tgt_qw <= '0;
      req_ch.tgt_qx <= '0;
      req_ch.tgt_qy <= '0;
      req_ch.tgt_qz <= '0;
      req_ch.rate_x <= '0;
      req_ch.rate_y <= '0;
      req_ch.rate_z <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Gains are still zero from reset.
      for (int i = 0; i < 4; i++)
         send_update(random_update());
      settle();

      load_gains(GAIN_FULL, GAIN_FULL);
      run_directed();
      settle();

      for (int phase = 0; phase < PHASES; phase++) begin
         load_gains(KP_STYLE[phase], KD_STYLE[phase]);
         // Back-to-back requests while the response side stalls fill the pipeline.
         allow_gaps = !(phase == 2 || phase == SQUEEZE_PHASE);
         if (phase == SQUEEZE_PHASE)
            squeeze_req = 1'b1;
         count = (phase == SQUEEZE_PHASE) ? SQUEEZE_REQUESTS : PHASE_REQUESTS;
         for (int i = 0; i < count; i++)
            send_update(random_update());
         settle();
      end

      if (mismatch_count == 0 && torque_pending == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
